// ===== hdl/pfv_pkg.sv =====
// pfv_pkg: shared types, codes and character constants for the phone field validator.
// No dependencies; used by the interfaces, the check logic, the top level and the checker.

package pfv_pkg;

  // Marker length and field byte codes
  localparam int unsigned MARKER_LEN = 13;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [4:0] PART_MAX    = 5'd31;
  localparam logic [1:0] BRACKET_MAX = 2'd3;
  // bracket count that lets a field end right after its brackets
  localparam logic [1:0] BRACKET_END = 2'd2;

  // Verdict codes; the sticky error uses the same encoding
  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_BAD_CHAR  = 2'd1,
    VERDICT_FEW_PARTS = 2'd2
  } verdict_t;

  // Line level codes; higher codes act as LVL_OTHER
  typedef enum logic [2:0] {
    LVL_PRIVATE = 3'd0,
    LVL_HOLD    = 3'd1,
    LVL_DOWN    = 3'd2,
    LVL_POINT   = 3'd3,
    LVL_OTHER   = 3'd4
  } level_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_PARTS     = 2'd0,
    CFG_ALPHA_ALLOWED = 2'd1,
    CFG_UNPUB_ALLOWED = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 8;

  typedef struct packed {
    logic [3:0] min_parts;
    logic       alpha_allowed;
    logic       unpub_allowed;
  } cfg_t;

  // Per-field scan state
  typedef struct packed {
    logic [3:0] char_position;
    logic       caseless_match;
    logic       exact_match;
    logic       letter_seen;
    logic       group_open;
    logic [4:0] part_count;
    logic [1:0] bracket_count;
    verdict_t   first_error;
  } field_state_t;

  localparam field_state_t FIELD_CLEAR = '{
    char_position:  4'd0,
    caseless_match: 1'b1,
    exact_match:    1'b1,
    letter_seen:    1'b0,
    group_open:     1'b0,
    part_count:     5'd0,
    bracket_count:  2'd0,
    first_error:    VERDICT_OK
  };

  // "-Unpublished-" one byte per position
  function automatic logic [7:0] marker_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h2D;
      4'd1:    c = 8'h55;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h70;
      4'd4:    c = 8'h75;
      4'd5:    c = 8'h62;
      4'd6:    c = 8'h6C;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h73;
      4'd9:    c = 8'h68;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h64;
      4'd12:   c = 8'h2D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Upper case letters map to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// ===== hdl/pfv_if.sv =====
// pfv_if: valid/ready channel interfaces for field bytes, verdicts and config writes.
// Depends on pfv_pkg for the config data width.

interface pfv_field_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [2:0] line_level;

  modport source (output valid, output ch, output line_level, input ready);
  modport sink   (input valid, input ch, input line_level, output ready);
endinterface

interface pfv_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       write_unpublished;

  modport source (output valid, output verdict, output write_unpublished, input ready);
  modport sink   (input valid, input verdict, input write_unpublished, output ready);
endinterface

interface pfv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        index;
  logic [pfv_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pfv_field_check.sv =====
// pfv_field_check: combinational update of the field scan state for one byte,
// plus the verdict formed on the terminating byte. Depends on pfv_pkg.

module pfv_field_check (
  input  pfv_pkg::field_state_t state,
  input  logic [7:0]            ch,
  input  logic [2:0]            line_level,
  input  pfv_pkg::cfg_t         cfg,
  output pfv_pkg::field_state_t state_next,
  output pfv_pkg::verdict_t     verdict,
  output logic                  write_unpublished
);

  pfv_pkg::field_state_t nxt;
  logic [4:0] part_inc;
  logic [1:0] bracket_inc;
  logic       is_digit;
  logic       early_short;
  logic [7:0] mk;
  logic       at_len;
  logic       marker_any;
  logic       marker_exact;
  logic       level_checked;

  // Saturating counters and byte classes
  assign part_inc    = (state.part_count == pfv_pkg::PART_MAX) ?
                       state.part_count : state.part_count + 5'd1;
  assign bracket_inc = (state.bracket_count == pfv_pkg::BRACKET_MAX) ?
                       state.bracket_count : state.bracket_count + 2'd1;
  assign is_digit    = (ch >= pfv_pkg::CH_ZERO) && (ch <= pfv_pkg::CH_NINE);
  assign early_short = ({1'b0, state.part_count} + 6'd1) < {2'b00, cfg.min_parts};
  assign mk          = pfv_pkg::marker_char(state.char_position);

  // Byte scan: part counting, bracket handling, marker compare
  always_comb begin
    nxt = state;
    if (state.first_error == pfv_pkg::VERDICT_OK) begin
      if (is_digit) begin
        nxt.group_open = 1'b1;
      end else if (state.group_open) begin
        case (ch)
          pfv_pkg::CH_LBRACK: begin
            if (early_short) begin
              nxt.first_error = pfv_pkg::VERDICT_FEW_PARTS;
            end else begin
              nxt.part_count    = 5'd0;
              nxt.bracket_count = bracket_inc;
              nxt.group_open    = 1'b0;
            end
          end
          pfv_pkg::CH_RBRACK: begin
            nxt.bracket_count = bracket_inc;
            nxt.group_open    = 1'b0;
            nxt.part_count    = part_inc;
          end
          pfv_pkg::CH_NUL, pfv_pkg::CH_DASH: begin
            nxt.group_open = 1'b0;
            nxt.part_count = part_inc;
          end
          default: nxt.first_error = pfv_pkg::VERDICT_BAD_CHAR;
        endcase
      end else if (!(ch == pfv_pkg::CH_NUL && state.bracket_count == pfv_pkg::BRACKET_END)) begin
        nxt.first_error = pfv_pkg::VERDICT_BAD_CHAR;
      end
      // end of field: total part count check
      if (ch == pfv_pkg::CH_NUL && nxt.first_error == pfv_pkg::VERDICT_OK &&
          nxt.part_count < {1'b0, cfg.min_parts}) begin
        nxt.first_error = pfv_pkg::VERDICT_FEW_PARTS;
      end
    end
    if (ch != pfv_pkg::CH_NUL) begin
      if (state.char_position < 4'(pfv_pkg::MARKER_LEN)) begin
        if (ch != mk) begin
          nxt.exact_match = 1'b0;
        end
        if (pfv_pkg::fold(ch) != pfv_pkg::fold(mk)) begin
          nxt.caseless_match = 1'b0;
        end
        nxt.char_position = state.char_position + 4'd1;
      end else begin
        nxt.exact_match    = 1'b0;
        nxt.caseless_match = 1'b0;
      end
      if (pfv_pkg::is_letter(ch)) begin
        nxt.letter_seen = 1'b1;
      end
    end
  end

  // Verdict on the terminating byte
  assign at_len        = state.char_position == 4'(pfv_pkg::MARKER_LEN);
  assign marker_any    = state.caseless_match && at_len;
  assign marker_exact  = state.exact_match && at_len;
  assign level_checked = line_level >= pfv_pkg::LVL_POINT;

  always_comb begin
    if (!level_checked) begin
      verdict = pfv_pkg::VERDICT_OK;
    end else if (line_level == pfv_pkg::LVL_POINT && marker_any) begin
      verdict = pfv_pkg::VERDICT_OK;
    end else if (cfg.unpub_allowed && marker_any) begin
      verdict = pfv_pkg::VERDICT_OK;
    end else if (cfg.alpha_allowed && marker_any) begin
      verdict = pfv_pkg::VERDICT_BAD_CHAR;
    end else if (cfg.alpha_allowed && state.letter_seen) begin
      verdict = pfv_pkg::VERDICT_OK;
    end else begin
      verdict = nxt.first_error;
    end
  end

  assign write_unpublished = !marker_exact && (marker_any || line_level == pfv_pkg::LVL_PRIVATE);

  // A finished field starts the next one from scratch
  assign state_next = (ch == pfv_pkg::CH_NUL) ? pfv_pkg::FIELD_CLEAR : nxt;

endmodule

// ===== hdl/phone_field_validator_top.sv =====
// phone_field_validator_top: top level of the phone field validator.
// Depends on pfv_pkg, the channel interfaces in pfv_if and pfv_field_check.
//
// Usage:
//   field  - byte stream of phone fields, one byte per request (ch, line_level).
//            A zero byte ends the field; only its line_level is used.
//   result - one request per field (verdict, write_unpublished), issued
//            for the terminating byte only; other bytes give no result.
//   cfg    - register writes (min_parts, alpha_allowed, unpub_allowed),
//            always ready; write only while no field is in flight.
// Timing: an accepted byte is captured in the input register and scanned
//   into the scan state; a terminating byte also loads the result register.
// Throughput: one byte per cycle unless a terminating byte is stalled. The
//   scan is one combinational pass between the input and result registers.
// Stall: the result register holds until taken. A terminating byte waits
//   in the input register meanwhile and the field channel deasserts ready;
//   other bytes keep flowing.
// Reset: clears the pipeline valids, the scan state and the registers to
//   min_parts = 1, alpha_allowed = 0, unpub_allowed = 0.

module phone_field_validator_top (
  input  logic             clk,
  input  logic             rst,
  pfv_field_if.sink        field,
  pfv_result_if.source     result,
  pfv_cfg_if.sink          cfg
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic [2:0] s1_level;

  // Scan state and configuration
  pfv_pkg::field_state_t fstate;
  pfv_pkg::field_state_t fstate_next;
  pfv_pkg::cfg_t         cfg_regs;

  // Result register
  logic              out_valid;
  pfv_pkg::verdict_t out_verdict;
  logic              out_wu;

  pfv_pkg::verdict_t chk_verdict;
  logic              chk_wu;
  logic              s1_term;
  logic              s1_done;
  logic              out_load;

  // Pipeline control
  assign s1_term     = s1_ch == pfv_pkg::CH_NUL;
  assign s1_done     = s1_valid && (!s1_term || !out_valid || result.ready);
  assign out_load    = s1_valid && s1_term && s1_done;
  assign field.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (field.ready) begin
      s1_valid <= field.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (field.ready && field.valid) begin
      s1_ch    <= field.ch;
      s1_level <= field.line_level;
    end
  end

  // Byte scan
  pfv_field_check u_check (
    .state             (fstate),
    .ch                (s1_ch),
    .line_level        (s1_level),
    .cfg               (cfg_regs),
    .state_next        (fstate_next),
    .verdict           (chk_verdict),
    .write_unpublished (chk_wu)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= pfv_pkg::FIELD_CLEAR;
    end else if (s1_done) begin
      fstate <= fstate_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict <= chk_verdict;
      out_wu      <= chk_wu;
    end
  end

  assign result.valid             = out_valid;
  assign result.verdict           = out_verdict;
  assign result.write_unpublished = out_wu;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.min_parts     <= 4'd1;
      cfg_regs.alpha_allowed <= 1'b0;
      cfg_regs.unpub_allowed <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pfv_pkg::CFG_MIN_PARTS:     cfg_regs.min_parts     <= cfg.data[3:0];
        pfv_pkg::CFG_ALPHA_ALLOWED: cfg_regs.alpha_allowed <= cfg.data[0];
        pfv_pkg::CFG_UNPUB_ALLOWED: cfg_regs.unpub_allowed <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/pfv_checker.sv =====
// pfv_checker: port-level assertions for phone_field_validator_top, bound to it below.
// Depends on pfv_pkg for the byte and verdict codes.

module pfv_checker (
  input logic       clk,
  input logic       rst,
  input logic       field_valid,
  input logic       field_ready,
  input logic [7:0] field_ch,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] result_verdict,
  input logic       result_wu
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_verdict) &&
                                      $stable(result_wu))
    else $error("stalled result changed");

  // A new result comes from a terminating byte that passed through the input register
  a_result_from_nul: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(field_valid && field_ready && field_ch == pfv_pkg::CH_NUL, 2))
    else $error("result without terminating byte");

  // Verdict is one of the defined codes
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_verdict == pfv_pkg::VERDICT_OK ||
                      result_verdict == pfv_pkg::VERDICT_BAD_CHAR ||
                      result_verdict == pfv_pkg::VERDICT_FEW_PARTS))
    else $error("undefined verdict code");

endmodule

bind phone_field_validator_top pfv_checker u_pfv_checker (
  .clk            (clk),
  .rst            (rst),
  .field_valid    (field.valid),
  .field_ready    (field.ready),
  .field_ch       (field.ch),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_verdict (result.verdict),
  .result_wu      (result.write_unpublished)
);

// ===== test/phone_field_validator_top_tb.sv =====
// phone_field_validator_top_tb: self-checking bench for the phone field validator.
// Depends on pfv_pkg, the channel interfaces in pfv_if and phone_field_validator_top.

module phone_field_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [8*13-1:0] MARK_BYTES = "-Unpublished-";
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct {
    pfv_pkg::verdict_t verdict;
    logic              rewrite;
  } verdict_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfv_field_if  field_ch();
  pfv_result_if result_ch();
  pfv_cfg_if    cfg_ch();

  phone_field_validator_top dut (
    .clk    (clk),
    .rst    (rst),
    .field  (field_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5ns clk = ~clk;

  // Bench-side register copy and scan state, owned by the monitor
  logic [3:0] reg_min_parts;
  logic       reg_alpha;
  logic       reg_unpub;

  logic [3:0]        seen_pos;
  logic              caseless_ok;
  logic              exact_ok;
  logic              has_letter;
  logic              in_digits;
  logic [4:0]        parts_n;
  logic [1:0]        brackets_n;
  pfv_pkg::verdict_t sticky_err;

  verdict_exp_t pending_verdicts[$];
  logic [7:0]   field_buf[$];

  int err_count     = 0;
  int verdicts_seen = 0;
  int bytes_sent    = 0;
  int cfg_writes    = 0;
  int cur_min       = 1;
  bit no_idle       = 1'b0;

  function automatic logic [7:0] mark_byte(input int p);
    return MARK_BYTES[8*(12-p) +: 8];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_scan();
    seen_pos    = '0;
    caseless_ok = 1'b1;
    exact_ok    = 1'b1;
    has_letter  = 1'b0;
    in_digits   = 1'b0;
    parts_n     = '0;
    brackets_n  = '0;
    sticky_err  = pfv_pkg::VERDICT_OK;
  endfunction

  function automatic void close_group();
    in_digits = 1'b0;
    if (parts_n != pfv_pkg::PART_MAX) begin
      parts_n = parts_n + 5'd1;
    end
  endfunction

  // Advance the scan by one byte; a terminator yields the verdict
  task automatic predict_verdict(input logic [7:0] c, input logic [2:0] lvl_in,
                                 output bit done, output verdict_exp_t res);
    logic            m;
    logic            e;
    pfv_pkg::level_t lvl;
    done = 1'b0;
    res.verdict = pfv_pkg::VERDICT_OK;
    res.rewrite = 1'b0;
    // digit and separator rules, frozen after the first error
    if (sticky_err == pfv_pkg::VERDICT_OK) begin
      if (c >= pfv_pkg::CH_ZERO && c <= pfv_pkg::CH_NINE) begin
        in_digits = 1'b1;
      end else if (in_digits) begin
        if (c == pfv_pkg::CH_LBRACK) begin
          if (int'(parts_n) + 1 < int'(reg_min_parts)) begin
            sticky_err = pfv_pkg::VERDICT_FEW_PARTS;
          end else begin
            parts_n = '0;
            if (brackets_n != pfv_pkg::BRACKET_MAX) brackets_n = brackets_n + 2'd1;
            in_digits = 1'b0;
          end
        end else if (c == pfv_pkg::CH_RBRACK) begin
          if (brackets_n != pfv_pkg::BRACKET_MAX) brackets_n = brackets_n + 2'd1;
          close_group();
        end else if (c == pfv_pkg::CH_NUL || c == pfv_pkg::CH_DASH) begin
          close_group();
        end else begin
          sticky_err = pfv_pkg::VERDICT_BAD_CHAR;
        end
      end else if (!(c == pfv_pkg::CH_NUL && brackets_n == pfv_pkg::BRACKET_END)) begin
        sticky_err = pfv_pkg::VERDICT_BAD_CHAR;
      end
      if (c == pfv_pkg::CH_NUL && sticky_err == pfv_pkg::VERDICT_OK &&
          parts_n < {1'b0, reg_min_parts}) begin
        sticky_err = pfv_pkg::VERDICT_FEW_PARTS;
      end
    end
    if (c != pfv_pkg::CH_NUL) begin
      // marker tracking
      if (seen_pos < pfv_pkg::MARKER_LEN) begin
        if (c != mark_byte(seen_pos)) exact_ok = 1'b0;
        if (to_lower(c) != to_lower(mark_byte(seen_pos))) caseless_ok = 1'b0;
        seen_pos = seen_pos + 4'd1;
      end else begin
        exact_ok    = 1'b0;
        caseless_ok = 1'b0;
      end
      if (alpha_byte(c)) has_letter = 1'b1;
    end else begin
      m   = caseless_ok && seen_pos == pfv_pkg::MARKER_LEN;
      e   = exact_ok && seen_pos == pfv_pkg::MARKER_LEN;
      lvl = (lvl_in > pfv_pkg::LVL_OTHER) ? pfv_pkg::LVL_OTHER : pfv_pkg::level_t'(lvl_in);
      if (lvl <= pfv_pkg::LVL_DOWN) res.verdict = pfv_pkg::VERDICT_OK;
      else if (lvl == pfv_pkg::LVL_POINT && m) res.verdict = pfv_pkg::VERDICT_OK;
      else if (reg_unpub && m) res.verdict = pfv_pkg::VERDICT_OK;
      else if (reg_alpha && m) res.verdict = pfv_pkg::VERDICT_BAD_CHAR;
      else if (reg_alpha && has_letter) res.verdict = pfv_pkg::VERDICT_OK;
      else res.verdict = sticky_err;
      res.rewrite = !e && (m || lvl == pfv_pkg::LVL_PRIVATE);
      done = 1'b1;
      clear_scan();
    end
  endtask

  // Monitor: register writes, accepted bytes and result checking
  always @(posedge clk) begin
    bit           done;
    verdict_exp_t res;
    verdict_exp_t want;
    if (rst) begin
      reg_min_parts = 4'd1;
      reg_alpha     = 1'b0;
      reg_unpub     = 1'b0;
      clear_scan();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result with nothing pending: verdict=%0d write_unpublished=%0b",
                 result_ch.verdict, result_ch.write_unpublished);
          err_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result_ch.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, result_ch.verdict);
            err_count++;
          end
          if (result_ch.write_unpublished !== want.rewrite) begin
            $error("write_unpublished: expected %0b, got %0b",
                   want.rewrite, result_ch.write_unpublished);
            err_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          pfv_pkg::CFG_MIN_PARTS:     reg_min_parts = cfg_ch.data[3:0];
          pfv_pkg::CFG_ALPHA_ALLOWED: reg_alpha     = cfg_ch.data[0];
          pfv_pkg::CFG_UNPUB_ALLOWED: reg_unpub     = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (field_ch.valid && field_ch.ready) begin
        predict_verdict(field_ch.ch, field_ch.line_level, done, res);
        if (done) pending_verdicts.push_back(res);
      end
    end
  end

  // Result-side backpressure: short stalls mostly, a few long ones
  initial begin
    int hold;
    result_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        result_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 3) != 0);
        hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // One byte request; returns once accepted, then maybe idles
  task automatic send_byte(input logic [7:0] c, input logic [2:0] lvl);
    int gap;
    @(negedge clk);
    field_ch.valid      <= 1'b1;
    field_ch.ch         <= c;
    field_ch.line_level <= lvl;
    do @(posedge clk); while (!field_ch.ready);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      field_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic field_idle();
    @(negedge clk);
    field_ch.valid <= 1'b0;
  endtask

  // Send the buffered field plus its terminator
  task automatic send_field(input logic [2:0] lvl);
    int i;
    for (i = 0; i < field_buf.size(); i++) begin
      send_byte(field_buf[i], 3'($urandom_range(0, 7)));
    end
    send_byte(pfv_pkg::CH_NUL, lvl);
    field_buf.delete();
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) field_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    int i;
    for (i = 0; i < n; i++) field_buf.push_back(pfv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_marker();
    int i;
    for (i = 0; i < pfv_pkg::MARKER_LEN; i++) field_buf.push_back(mark_byte(i));
  endtask

  task automatic add_phone(input int nparts, input bit bracketed);
    int i;
    int n;
    for (i = 0; i < nparts; i++) begin
      if (i != 0) field_buf.push_back(pfv_pkg::CH_DASH);
      add_digits($urandom_range(1, 4));
    end
    if (bracketed) begin
      field_buf.push_back(pfv_pkg::CH_LBRACK);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        if (i != 0) field_buf.push_back(pfv_pkg::CH_DASH);
        add_digits($urandom_range(1, 3));
      end
      if ($urandom_range(0, 2) != 0) field_buf.push_back(pfv_pkg::CH_RBRACK);
    end
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only with the block idle; unused data bits are random
  task automatic set_config(input int min_parts, input bit alpha, input bit unpub);
    logic [7:0] d;
    field_idle();
    wait_drained();
    d = 8'($urandom);
    d[3:0] = 4'(min_parts);
    write_reg(pfv_pkg::CFG_MIN_PARTS, d);
    d = 8'($urandom);
    d[0] = alpha;
    write_reg(pfv_pkg::CFG_ALPHA_ALLOWED, d);
    d = 8'($urandom);
    d[0] = unpub;
    write_reg(pfv_pkg::CFG_UNPUB_ALLOWED, d);
    cur_min = min_parts;
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range("A", "Z"))
                                       : 8'($urandom_range("a", "z"));
  endfunction

  function automatic logic [2:0] rand_level();
    if ($urandom_range(0, 99) < 60) begin
      return ($urandom_range(0, 1) != 0) ? pfv_pkg::LVL_POINT : pfv_pkg::LVL_OTHER;
    end
    return 3'($urandom_range(0, 7));
  endfunction

  // Build one random field, mostly well formed
  task automatic build_random_field();
    int kind;
    int n;
    int i;
    int pos;
    int lo;
    kind = $urandom_range(0, 99);
    lo   = (cur_min > 1) ? cur_min - 1 : 1;
    if (kind < 45) begin
      add_phone($urandom_range(lo, cur_min + 2), $urandom_range(0, 3) == 0);
    end else if (kind < 57) begin
      // marker, sometimes case-mangled or damaged
      add_marker();
      if ($urandom_range(0, 1) != 0) begin
        for (i = 0; i < field_buf.size(); i++) begin
          if (alpha_byte(field_buf[i]) && $urandom_range(0, 1) != 0) begin
            field_buf[i] = field_buf[i] ^ 8'h20;
          end
        end
      end
      case ($urandom_range(0, 5))
        0: field_buf[$urandom_range(0, pfv_pkg::MARKER_LEN - 1)] = 8'($urandom_range(1, 255));
        1: field_buf.push_back(8'($urandom_range(1, 255)));
        2: void'(field_buf.pop_back());
        default: ;
      endcase
    end else if (kind < 66) begin
      // alphanumeric text
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       add_digits(1);
          1:       field_buf.push_back(pfv_pkg::CH_DASH);
          default: field_buf.push_back(rand_letter());
        endcase
      end
    end else if (kind < 80) begin
      // phone with one damaged byte
      add_phone($urandom_range(lo, cur_min + 2), $urandom_range(0, 3) == 0);
      pos = $urandom_range(0, field_buf.size() - 1);
      field_buf[pos] = 8'($urandom_range(1, 255));
    end else if (kind < 90) begin
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) field_buf.push_back(8'($urandom_range(1, 255)));
    end else if (kind < 96) begin
      // broken separators around a valid body
      add_phone($urandom_range(1, cur_min + 1), 1'b0);
      case ($urandom_range(0, 4))
        0: field_buf.push_front(pfv_pkg::CH_DASH);
        1: field_buf.push_back(pfv_pkg::CH_DASH);
        2: field_buf.push_front(pfv_pkg::CH_LBRACK);
        3: begin
          field_buf.push_back(pfv_pkg::CH_RBRACK);
          field_buf.push_back(pfv_pkg::CH_RBRACK);
        end
        default: begin
          field_buf.push_back(pfv_pkg::CH_DASH);
          field_buf.push_back(pfv_pkg::CH_DASH);
          add_digits(2);
        end
      endcase
    end else begin
      // thirty to forty groups, in most cases enough to saturate the part counter
      n = $urandom_range(30, 40);
      for (i = 0; i < n; i++) begin
        if (i != 0) field_buf.push_back(pfv_pkg::CH_DASH);
        add_digits(1);
      end
    end
  endtask

  // Plain fields under the reset settings
  task automatic test_reset_settings();
    add_text("1-234-5");  send_field(pfv_pkg::LVL_OTHER);
    send_field(pfv_pkg::LVL_OTHER);
    send_field(pfv_pkg::LVL_PRIVATE);
    add_text("12a");      send_field(pfv_pkg::LVL_HOLD);
    add_text("-x");       send_field(pfv_pkg::LVL_DOWN);
    add_text("5-");       send_field(pfv_pkg::LVL_OTHER);
    field_buf.push_back(8'hFF);
    send_field(3'd7);
    add_text("1[2]");     send_field(pfv_pkg::LVL_OTHER);
    add_text("1[2]3");    send_field(pfv_pkg::LVL_POINT);
  endtask

  // Unpublished marker in its exact, caseless, long and short forms
  task automatic test_marker_forms();
    add_marker();               send_field(pfv_pkg::LVL_PRIVATE);
    add_text("-UNPUBLISHED-");  send_field(pfv_pkg::LVL_POINT);
    add_marker();               send_field(pfv_pkg::LVL_OTHER);
    add_text("-Unpublished-X"); send_field(pfv_pkg::LVL_POINT);
    add_text("-unpublishe");    send_field(pfv_pkg::LVL_POINT);
  endtask

  // Letter and marker options, and the min_parts extremes
  task automatic test_options();
    set_config(0, 1'b1, 1'b0);
    send_field(pfv_pkg::LVL_OTHER);
    add_marker();              send_field(pfv_pkg::LVL_OTHER);
    add_text("abc");           send_field(pfv_pkg::LVL_OTHER);
    set_config(15, 1'b0, 1'b1);
    write_reg(CFG_UNUSED, 8'($urandom));
    add_marker();              send_field(pfv_pkg::LVL_OTHER);
    add_text("-uNpUbLiShEd-"); send_field(3'd5);
    add_phone(14, 1'b0);       send_field(pfv_pkg::LVL_OTHER);
    add_phone(15, 1'b0);       send_field(pfv_pkg::LVL_POINT);
  endtask

  // Bracket rules, bracket saturation and bytes after an error
  task automatic test_brackets();
    set_config(3, 1'b0, 1'b0);
    add_text("1-2[3-4-5]");    send_field(pfv_pkg::LVL_OTHER);
    add_text("1-2-3[4-5-6]");  send_field(pfv_pkg::LVL_OTHER);
    add_text("1]2]3]4]");      send_field(pfv_pkg::LVL_OTHER);
    add_text("1-2-3[4-5-6[7-8-9]"); send_field(pfv_pkg::LVL_POINT);
    add_text("9-0");
    field_buf.push_back(CH_TILDE);
    add_text("5-6");           send_field(pfv_pkg::LVL_OTHER);
  endtask

  // Random fields under one register setting
  task automatic test_random_phase(input int min_parts, input bit alpha, input bit unpub,
                                   input int budget);
    int stop_at;
    set_config(min_parts, alpha, unpub);
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      build_random_field();
      send_field(rand_level());
    end
  endtask

  initial begin
    field_ch.valid      = 1'b0;
    field_ch.ch         = '0;
    field_ch.line_level = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_marker_forms();
    test_options();
    test_brackets();
    test_random_phase(1, 1'b0, 1'b0, 170);
    test_random_phase(0, 1'b1, 1'b1, 170);
    test_random_phase(15, 1'b0, 1'b1, 170);
    test_random_phase(2, 1'b1, 1'b0, 170);
    test_random_phase($urandom_range(0, 15), 1'($urandom), 1'($urandom), 170);
    no_idle = 1'b1;
    test_random_phase(3, 1'b0, 1'b0, 130);
    no_idle = 1'b0;

    field_idle();
    wait_drained();
    $display("Sent %0d field bytes under %0d register writes; checked %0d verdicts.",
             bytes_sent, cfg_writes, verdicts_seen);
    $display("Mismatches found: %0d", err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Run stopped by watchdog with %0d verdicts pending", pending_verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
